### design/fraction_multiply_reduce_macros.svh
// Assertion macros shared by the fraction multiply block.
`ifndef FRACTION_MULTIPLY_REDUCE_MACROS_SVH
`define FRACTION_MULTIPLY_REDUCE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define FMR_ASSERT_IMP(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define FMR_ASSERT_NXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

### design/fmr_pkg.sv
// Types and constants for the fraction multiply block.
`timescale 1ns / 1ps
package fmr_pkg;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned CNT_W  = 6;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b0_0000_0001,
        ST_MULN = 9'b0_0000_0010,
        ST_MULD = 9'b0_0000_0100,
        ST_SIGN = 9'b0_0000_1000,
        ST_GCD  = 9'b0_0001_0000,
        ST_DIVD = 9'b0_0010_0000,
        ST_DIV  = 9'b0_0100_0000,
        ST_FIN  = 9'b0_1000_0000,
        ST_OUT  = 9'b1_0000_0000
    } state_t;

    // what the running divide is for
    typedef enum logic [1:0] {
        PH_GCD = 2'd0,
        PH_NUM = 2'd1,
        PH_DEN = 2'd2
    } phase_t;
endpackage

### design/fraction_multiply_reduce.sv
// Fraction multiplier with gcd reduction built around one shared divider.
//
// Usage: s_axis word carries a_num, a_den, b_num, b_den (IN_WIDTH bits each,
// two's complement). m_axis word carries prod_num, prod_den (64 bits each)
// with zero_den_error in tuser. One result word per input word.
// Flow: the two products are formed one after the other by one multiplier, signs
// are fixed, then Euclid runs on one radix-2 restoring divider that yields
// one quotient bit per cycle. The two final exact divisions reuse the same divider.
// A zero denominator or zero numerator skips Euclid and the divisions and
// goes straight from the sign step to the output register.
// The block takes one word at a time: s_axis_tready is high only when idle.
// The result sits in an output register, so the next word may be taken and
// worked on while it waits; a stalled receiver then holds the second result
// in the final state and the input stays blocked until the first is taken.
// Reset (aresetn low, synchronous) returns to idle and drops m_axis_tvalid.
`timescale 1ns / 1ps
`include "fraction_multiply_reduce_macros.svh"
module fraction_multiply_reduce #(
    parameter int IN_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // tdata: a_num, a_den, b_num, b_den from bit 0 up, zero filled to bytes
    input  logic [((4*IN_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: prod_num [63:0], prod_den [127:64]
    output logic [2*fmr_pkg::PROD_W-1:0] m_axis_tdata,
    // tuser: zero_den_error
    output logic                    m_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready
);
    import fmr_pkg::*;

    localparam int unsigned W = PROD_W;

    state_t state_reg, state_next;
    phase_t phase_reg;
    logic signed [IN_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [W-1:0] pn_reg, pd_reg, n_reg, d_reg, g_reg;
    // divider: magnitudes, remainder, quotient
    logic [W-1:0] dvd_reg, dvs_reg, rem_reg, quo_reg;
    logic         qneg_reg, rneg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [2*W-1:0] out_data_reg;
    logic         out_err_reg, out_valid_reg;
    logic         in_fire;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        mag = v[W-1] ? W'(-v) : W'(v);
    endfunction

    // shared multiplier: numerators first, then denominators
    logic signed [IN_WIDTH-1:0] mul_a, mul_b;
    logic signed [2*IN_WIDTH-1:0] mul_p;
    logic signed [W-1:0] mul_ext;
    assign mul_a   = (state_reg == ST_MULN) ? an_reg : ad_reg;
    assign mul_b   = (state_reg == ST_MULN) ? bn_reg : bd_reg;
    assign mul_p   = mul_a * mul_b;
    assign mul_ext = W'(mul_p);

    // one restoring step
    logic [W:0] trial;
    logic [W-1:0] shifted;
    assign shifted = {rem_reg[W-2:0], dvd_reg[W-1]};
    assign trial   = {1'b0, shifted} - {1'b0, dvs_reg};

    // signed quotient and truncating remainder
    logic signed [W-1:0] quo_s, rem_s;
    assign quo_s = qneg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign rem_s = rneg_reg ? -$signed(rem_reg) : $signed(rem_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;
    assign m_axis_tvalid = out_valid_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_MULN;
            ST_MULN: state_next = ST_MULD;
            ST_MULD: state_next = ST_SIGN;
            ST_SIGN: begin
                if (pd_reg == '0 || pn_reg == '0) state_next = ST_OUT;
                else state_next = ST_GCD;
            end
            ST_GCD:  state_next = ST_DIV;
            ST_DIVD: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_FIN;
            ST_FIN: begin
                unique case (phase_reg)
                    PH_GCD:  state_next = ST_GCD;
                    PH_NUM:  state_next = ST_DIVD;
                    default: state_next = ST_OUT;
                endcase
            end
            ST_OUT:  if (!out_valid_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_GCD;
            cnt_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (in_fire) begin
                    an_reg <= s_axis_tdata[IN_WIDTH-1:0];
                    ad_reg <= s_axis_tdata[2*IN_WIDTH-1:IN_WIDTH];
                    bn_reg <= s_axis_tdata[3*IN_WIDTH-1:2*IN_WIDTH];
                    bd_reg <= s_axis_tdata[4*IN_WIDTH-1:3*IN_WIDTH];
                end
                ST_MULN: pn_reg <= mul_ext;
                ST_MULD: pd_reg <= mul_ext;
                ST_SIGN: begin
                    // both negative: negate both
                    if (pn_reg[W-1] && pd_reg[W-1]) begin
                        pn_reg <= -pn_reg;
                        pd_reg <= -pd_reg;
                        n_reg  <= -pn_reg;
                        d_reg  <= -pd_reg;
                    end else begin
                        n_reg <= pn_reg;
                        d_reg <= pd_reg;
                    end
                end
                ST_GCD: begin
                    if (d_reg == '0) begin
                        // gcd found: start the numerator divide
                        g_reg     <= n_reg;
                        dvd_reg   <= mag(pn_reg);
                        dvs_reg   <= mag(n_reg);
                        qneg_reg  <= pn_reg[W-1] ^ n_reg[W-1];
                        rneg_reg  <= 1'b0;
                        phase_reg <= PH_NUM;
                    end else begin
                        // start n % d
                        dvd_reg   <= mag(n_reg);
                        dvs_reg   <= mag(d_reg);
                        qneg_reg  <= n_reg[W-1] ^ d_reg[W-1];
                        rneg_reg  <= n_reg[W-1];
                        phase_reg <= PH_GCD;
                    end
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= CNT_W'(W - 1);
                end
                ST_DIVD: begin
                    dvd_reg   <= mag(pd_reg);
                    dvs_reg   <= mag(g_reg);
                    qneg_reg  <= pd_reg[W-1] ^ g_reg[W-1];
                    rneg_reg  <= 1'b0;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= CNT_W'(W - 1);
                    phase_reg <= PH_DEN;
                end
                ST_DIV: begin
                    dvd_reg <= {dvd_reg[W-2:0], 1'b0};
                    if (!trial[W]) begin
                        rem_reg <= trial[W-1:0];
                        quo_reg <= {quo_reg[W-2:0], 1'b1};
                    end else begin
                        rem_reg <= shifted;
                        quo_reg <= {quo_reg[W-2:0], 1'b0};
                    end
                    if (cnt_reg != '0) cnt_reg <= cnt_reg - 1'b1;
                end
                ST_FIN: begin
                    // pick up the divider result
                    unique case (phase_reg)
                        PH_GCD: begin
                            n_reg <= d_reg;
                            d_reg <= rem_s;
                        end
                        PH_NUM:  pn_reg <= quo_s;
                        default: pd_reg <= quo_s;
                    endcase
                end
                ST_OUT: if (!out_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    out_err_reg   <= (pd_reg == '0);
                    if (pd_reg == '0) out_data_reg <= '0;
                    else out_data_reg <= {pd_reg, pn_reg};
                end
                default: ;
            endcase
        end
    end

    `FMR_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_axis_tready, state_reg == ST_IDLE, "input ready outside idle")
    `FMR_ASSERT_NXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
    `FMR_ASSERT_IMP(a_err_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error word carries data")
    `FMR_ASSERT_IMP(a_state_onehot, aclk, aresetn, 1'b1, $onehot(state_reg), "state not one-hot")
endmodule
